### hdl/gctb_pkg.sv
`default_nettype none
package gctb_pkg;

    localparam int NUM_SLOTS_DEF = 16;
    localparam int MAX_RESULTS   = 16;
    localparam logic [31:0] LFSR_TAPS = 32'h8020_0003;

    typedef enum logic [2:0] {
        OP_ADD           = 3'd0,
        OP_SET_START     = 3'd1,
        OP_DISABLE       = 3'd2,
        OP_REDUCE        = 3'd3,
        OP_DELAY         = 3'd4,
        OP_START_IF_IDLE = 3'd5,
        OP_TICK          = 3'd6,
        OP_RESET_ALL     = 3'd7
    } op_t;

    typedef enum logic [1:0] {
        ST_DONE    = 2'd0,
        ST_MISSING = 2'd1,
        ST_PRESENT = 2'd2,
        ST_EXPIRED = 2'd3
    } status_t;

    localparam logic [1:0] GATE_ALWAYS = 2'd2;

    typedef struct packed {
        logic [2:0]  operation;
        logic [3:0]  slot;
        logic [31:0] value;
        logic [31:0] value_max;
        logic [1:0]  gate_mode;
        logic        start_disabled;
        logic        in_combat;
    } in_item_t;

    typedef struct packed {
        logic [1:0] status;
        logic [3:0] expired_slot;
        logic       last;
    } out_item_t;

    // one slot as kept in the slot memory
    typedef struct packed {
        logic [31:0] remaining;
        logic [31:0] rmin;
        logic [31:0] rmax;
        logic        rdis;
        logic [1:0]  gate;
        logic        dis;
    } entry_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_DECODE,
        S_EXEC,
        S_TICK,
        S_TICK_END,
        S_DRAW_RD,
        S_DRAW_SPAN,
        S_DRAW_MUL,
        S_DRAW_SUM,
        S_DRAW_WR,
        S_RESP
    } state_t;

    typedef struct packed {
        logic load;
        logic decode;
        logic rd_en;
        logic rd_next;
        logic idx_inc;
        logic exec_single;
        logic tick_step;
        logic tick_end;
        logic draw_span;
        logic draw_mul;
        logic draw_sum;
        logic draw_wr;
        logic resp_push;
    } cmd_t;

    typedef struct packed {
        op_t  op;
        logic range_ok;
        logic present_ok;
        logic idx_last;
        logic idx_present;
        logic tick_stall;
        logic out_free;
    } stat_t;

endpackage
`default_nettype wire

### hdl/gated_countdown_timer_bank_core.sv
`default_nettype none
// Each transaction runs through the controller states: a single-slot operation reads,
// updates and writes back its slot; a missing or already present slot goes straight to
// the result; an add draws and writes its slot; a tick walks every slot (and may wait on
// the result side); reset-all walks every slot and redraws each present one. Throughput:
// one transaction at a time, the next taken in the cycle after the last result is loaded.
// Reset: bank empty, generator at 1, no result pending; no clearing pass.
module gated_countdown_timer_bank_core #(
    parameter int NUM_SLOTS = gctb_pkg::NUM_SLOTS_DEF
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               in_valid,
    output logic                    in_ready,
    input  wire gctb_pkg::in_item_t in_item,
    output logic                    out_valid,
    input  wire logic               out_ready,
    output gctb_pkg::out_item_t     out_item,
    input  wire logic               cfg_valid,
    output logic                    cfg_ready,
    input  wire logic [31:0]        cfg_data
);
    import gctb_pkg::*;

    cmd_t  cmd;
    stat_t st;

    // seed writes are always taken
    assign cfg_ready = 1'b1;

    gctb_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .st       (st),
        .cmd      (cmd)
    );

    gctb_dp #(
        .NUM_SLOTS (NUM_SLOTS)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_item   (in_item),
        .cfg_valid (cfg_valid),
        .cfg_data  (cfg_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_item  (out_item),
        .cmd       (cmd),
        .st        (st)
    );

endmodule
`default_nettype wire

### hdl/gctb_ctrl.sv
`default_nettype none
module gctb_ctrl (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           in_valid,
    output logic                in_ready,
    input  wire gctb_pkg::stat_t st,
    output gctb_pkg::cmd_t      cmd
);
    import gctb_pkg::*;

    state_t state_reg;
    state_t state_next;

    // hold state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // sequence each transaction through the datapath
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_DECODE;
                end
            end
            S_DECODE:
            begin
                cmd.decode = 1'b1;
                if (st.op == OP_TICK)
                begin
                    cmd.rd_en  = 1'b1;
                    state_next = S_TICK;
                end
                else if (st.op == OP_RESET_ALL)
                begin
                    state_next = S_DRAW_RD;
                end
                else if (st.op == OP_ADD)
                begin
                    if (!st.range_ok || st.present_ok)
                    begin
                        state_next = S_RESP;
                    end
                    else
                    begin
                        state_next = S_DRAW_SPAN;
                    end
                end
                else if (st.range_ok && st.present_ok)
                begin
                    cmd.rd_en  = 1'b1;
                    state_next = S_EXEC;
                end
                else
                begin
                    state_next = S_RESP;
                end
            end
            S_EXEC:
            begin
                cmd.exec_single = 1'b1;
                state_next      = S_RESP;
            end
            S_TICK:
            begin
                if (!st.tick_stall)
                begin
                    cmd.tick_step = 1'b1;
                    if (st.idx_last)
                    begin
                        state_next = S_TICK_END;
                    end
                    else
                    begin
                        cmd.rd_en   = 1'b1;
                        cmd.rd_next = 1'b1;
                        cmd.idx_inc = 1'b1;
                    end
                end
            end
            S_TICK_END:
            begin
                if (st.out_free)
                begin
                    cmd.tick_end = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            S_DRAW_RD:
            begin
                if (st.idx_present)
                begin
                    cmd.rd_en  = 1'b1;
                    state_next = S_DRAW_SPAN;
                end
                else if (st.idx_last)
                begin
                    state_next = S_RESP;
                end
                else
                begin
                    cmd.idx_inc = 1'b1;
                end
            end
            S_DRAW_SPAN:
            begin
                cmd.draw_span = 1'b1;
                state_next    = S_DRAW_MUL;
            end
            S_DRAW_MUL:
            begin
                cmd.draw_mul = 1'b1;
                state_next   = S_DRAW_SUM;
            end
            S_DRAW_SUM:
            begin
                cmd.draw_sum = 1'b1;
                state_next   = S_DRAW_WR;
            end
            S_DRAW_WR:
            begin
                cmd.draw_wr = 1'b1;
                if (st.op == OP_ADD || st.idx_last)
                begin
                    state_next = S_RESP;
                end
                else
                begin
                    cmd.idx_inc = 1'b1;
                    state_next  = S_DRAW_RD;
                end
            end
            S_RESP:
            begin
                if (st.out_free)
                begin
                    cmd.resp_push = 1'b1;
                    state_next    = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule
`default_nettype wire

### hdl/gctb_dp.sv
`default_nettype none
module gctb_dp #(
    parameter int NUM_SLOTS = gctb_pkg::NUM_SLOTS_DEF
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire gctb_pkg::in_item_t in_item,
    input  wire logic               cfg_valid,
    input  wire logic [31:0]        cfg_data,
    output logic                    out_valid,
    input  wire logic               out_ready,
    output gctb_pkg::out_item_t     out_item,
    input  wire gctb_pkg::cmd_t     cmd,
    output gctb_pkg::stat_t         st
);
    import gctb_pkg::*;

    localparam int IDX_W = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
    localparam int CNT_W = $clog2(MAX_RESULTS + 1);

    in_item_t         item_reg;
    logic [IDX_W-1:0] idx_reg;
    logic [NUM_SLOTS-1:0] present_reg;
    logic [31:0]      lfsr_reg;
    status_t          status_reg;

    entry_t           mem [NUM_SLOTS];
    entry_t           rdata_reg;

    logic [31:0]      lo_reg;
    logic [31:0]      hi_reg;
    logic [31:0]      span_reg;
    logic [63:0]      prod_reg;
    logic [31:0]      draw_hi_reg;

    logic             pend_valid_reg;
    logic [3:0]       pend_slot_reg;
    logic [CNT_W-1:0] cnt_reg;

    logic             out_valid_reg;
    out_item_t        out_item_reg;

    op_t              op;
    logic             walk;
    logic [IDX_W-1:0] slot_addr;
    logic [IDX_W-1:0] idx_plus;
    logic [IDX_W-1:0] rd_addr;
    logic [IDX_W-1:0] wr_addr;
    logic             wr_en;
    entry_t           wr_data;
    logic             range_ok;
    logic             out_free;
    logic [31:0]      lfsr_step;
    logic [63:0]      sum_full;
    logic [31:0]      vlo;
    logic [31:0]      vhi;
    logic             tick_match;
    logic             tick_expire;
    logic             tick_report;
    entry_t           exec_e;
    logic             push;
    out_item_t        push_item;

    assign op        = op_t'(item_reg.operation);
    assign walk      = (op == OP_TICK) || (op == OP_RESET_ALL);
    assign slot_addr = IDX_W'(item_reg.slot);
    assign idx_plus  = idx_reg + 1'b1;
    assign rd_addr   = cmd.rd_next ? idx_plus : (walk ? idx_reg : slot_addr);
    assign wr_addr   = walk ? idx_reg : slot_addr;
    assign range_ok  = 9'(item_reg.slot) < 9'(NUM_SLOTS);
    assign out_free  = !out_valid_reg || out_ready;
    assign lfsr_step = (lfsr_reg >> 1) ^ (lfsr_reg[0] ? LFSR_TAPS : 32'd0);
    assign sum_full  = prod_reg + {32'd0, lfsr_reg};
    assign vlo       = (item_reg.value < item_reg.value_max) ? item_reg.value
                                                             : item_reg.value_max;
    assign vhi       = (item_reg.value < item_reg.value_max) ? item_reg.value_max
                                                             : item_reg.value;

    // tick decision for the slot under the walk pointer
    assign tick_match  = present_reg[idx_reg] && !rdata_reg.dis &&
                         (rdata_reg.gate == GATE_ALWAYS ||
                          rdata_reg.gate == {1'b0, item_reg.in_combat});
    assign tick_expire = tick_match && (rdata_reg.remaining <= item_reg.value);
    assign tick_report = tick_expire && (cnt_reg < CNT_W'(MAX_RESULTS));

    // single-slot operation on the entry just read
    always_comb
    begin
        exec_e = rdata_reg;
        unique case (op)
            OP_SET_START:
            begin
                exec_e.remaining = item_reg.value;
                exec_e.dis       = 1'b0;
            end
            OP_DISABLE:
            begin
                exec_e.remaining = 32'd0;
                exec_e.dis       = 1'b1;
            end
            OP_REDUCE:
            begin
                if (item_reg.value < rdata_reg.remaining)
                begin
                    exec_e.remaining = item_reg.value;
                end
            end
            OP_DELAY:
            begin
                if (!rdata_reg.dis && item_reg.value > rdata_reg.remaining)
                begin
                    exec_e.remaining = item_reg.value;
                end
            end
            OP_START_IF_IDLE:
            begin
                if (rdata_reg.dis)
                begin
                    exec_e.remaining = item_reg.value;
                    exec_e.dis       = 1'b0;
                end
            end
            default:
            begin
                exec_e = rdata_reg;
            end
        endcase
    end

    // memory write selection
    always_comb
    begin
        wr_en   = 1'b0;
        wr_data = rdata_reg;
        if (cmd.exec_single)
        begin
            wr_en   = 1'b1;
            wr_data = exec_e;
        end
        else if (cmd.tick_step && tick_match)
        begin
            wr_en = 1'b1;
            if (tick_expire)
            begin
                wr_data.remaining = 32'd0;
                wr_data.dis       = 1'b1;
            end
            else
            begin
                wr_data.remaining = rdata_reg.remaining - item_reg.value;
            end
        end
        else if (cmd.draw_wr)
        begin
            wr_en             = 1'b1;
            wr_data.remaining = lo_reg + draw_hi_reg;
            if (op == OP_ADD)
            begin
                wr_data.rmin = lo_reg;
                wr_data.rmax = hi_reg;
                wr_data.rdis = item_reg.start_disabled;
                wr_data.gate = item_reg.gate_mode;
                wr_data.dis  = item_reg.start_disabled;
            end
            else
            begin
                wr_data.dis = rdata_reg.rdis;
            end
        end
    end

    // slot memory with registered read
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (cmd.rd_en)
        begin
            rdata_reg <= mem[rd_addr];
        end
    end

    // result selection
    always_comb
    begin
        push      = 1'b0;
        push_item = '0;
        if (cmd.tick_step && tick_report && pend_valid_reg)
        begin
            push                   = 1'b1;
            push_item.status       = ST_EXPIRED;
            push_item.expired_slot = pend_slot_reg;
        end
        else if (cmd.tick_end)
        begin
            push           = 1'b1;
            push_item.last = 1'b1;
            if (pend_valid_reg)
            begin
                push_item.status       = ST_EXPIRED;
                push_item.expired_slot = pend_slot_reg;
            end
        end
        else if (cmd.resp_push)
        begin
            push             = 1'b1;
            push_item.status = status_reg;
            push_item.last   = 1'b1;
        end
    end

    // item, walk pointer, pending expiry and draw pipeline
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            item_reg <= in_item;
        end
        if (cmd.decode)
        begin
            if (walk)
            begin
                status_reg <= ST_DONE;
            end
            else if (!range_ok)
            begin
                status_reg <= ST_MISSING;
            end
            else if (op == OP_ADD)
            begin
                status_reg <= present_reg[slot_addr] ? ST_PRESENT : ST_DONE;
            end
            else
            begin
                status_reg <= present_reg[slot_addr] ? ST_DONE : ST_MISSING;
            end
        end
        if (cmd.tick_step && tick_report)
        begin
            pend_slot_reg <= 4'(idx_reg);
        end
        if (cmd.draw_span)
        begin
            if (op == OP_ADD)
            begin
                lo_reg   <= vlo;
                hi_reg   <= vhi;
                span_reg <= vhi - vlo;
            end
            else
            begin
                lo_reg   <= rdata_reg.rmin;
                hi_reg   <= rdata_reg.rmax;
                span_reg <= rdata_reg.rmax - rdata_reg.rmin;
            end
        end
        if (cmd.draw_sum)
        begin
            draw_hi_reg <= sum_full[63:32];
        end
        if (cmd.draw_mul)
        begin
            prod_reg <= {32'd0, lfsr_step} * {32'd0, span_reg};
        end
        if (push)
        begin
            out_item_reg <= push_item;
        end
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg        <= '0;
            present_reg    <= '0;
            lfsr_reg       <= 32'd1;
            pend_valid_reg <= 1'b0;
            cnt_reg        <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (cmd.load)
            begin
                idx_reg        <= '0;
                pend_valid_reg <= 1'b0;
                cnt_reg        <= '0;
            end
            else if (cmd.idx_inc)
            begin
                idx_reg <= idx_plus;
            end
            if (cmd.tick_step && tick_report)
            begin
                pend_valid_reg <= 1'b1;
                cnt_reg        <= cnt_reg + 1'b1;
            end
            if (cmd.draw_wr && op == OP_ADD)
            begin
                present_reg[slot_addr] <= 1'b1;
            end
            if (cfg_valid)
            begin
                lfsr_reg <= (cfg_data == 32'd0) ? 32'd1 : cfg_data;
            end
            else if (cmd.draw_mul)
            begin
                lfsr_reg <= lfsr_step;
            end
            if (push)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign out_valid      = out_valid_reg;
    assign out_item       = out_item_reg;

    assign st.op          = op;
    assign st.range_ok    = range_ok;
    assign st.present_ok  = present_reg[slot_addr];
    assign st.idx_last    = (idx_reg == IDX_W'(NUM_SLOTS - 1));
    assign st.idx_present = present_reg[idx_reg];
    assign st.tick_stall  = tick_report && pend_valid_reg && !out_free;
    assign st.out_free    = out_free;

endmodule
`default_nettype wire
